### rtl/assert_macros.svh
// Assertion macros shared by the checker files of the URL splitter.
// Each macro checks one property on the rising clock edge, disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ucs_pkg.sv
// Shared types and constants for the URL component splitter.
// No dependencies; imported by every module of the block.
package ucs_pkg;

    // Parsing phase of the URL under way.
    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_SLASH1 = 3'd1,
        PH_SLASH2 = 3'd2,
        PH_HOST   = 3'd3,
        PH_PORT   = 3'd4,
        PH_PATH   = 3'd5,
        PH_QUERY  = 3'd6,
        PH_FRAG   = 3'd7
    } phase_t;

    // Component tag reported with each item.
    typedef enum logic [2:0] {
        PART_SCHEME = 3'd0,
        PART_HOST   = 3'd1,
        PART_PORT   = 3'd2,
        PART_PATH   = 3'd3,
        PART_QUERY  = 3'd4,
        PART_FRAG   = 3'd5,
        PART_SEP    = 3'd6,
        PART_END    = 3'd7
    } part_t;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [3:0] SCHEME_LEN_RESET = 4'd5;
    localparam logic [3:0] SCHEME_COUNT_MAX = 4'd15;

    // Per-URL parsing state carried from item to item.
    typedef struct packed {
        phase_t     phase;
        logic [3:0] scheme_count;
        logic       host_seen;
        logic       failed;
    } url_state_t;

    localparam url_state_t URL_STATE_RESET = '{
        phase:        PH_SCHEME,
        scheme_count: 4'd0,
        host_seen:    1'b0,
        failed:       1'b0
    };

    // One result item.
    typedef struct packed {
        logic [7:0] char_out;
        part_t      part;
        logic       error;
        logic       url_end;
    } result_t;

endpackage

### rtl/ucs_classify.sv
// Combinational classification of one URL byte against the current parsing state.
// Depends on ucs_pkg for the state, result types and character constants.
module ucs_classify (
    input  logic [7:0]          ch,
    input  logic [3:0]          max_scheme_len,
    input  ucs_pkg::url_state_t state_cur,
    output ucs_pkg::url_state_t state_next,
    output ucs_pkg::result_t    result
);
    import ucs_pkg::*;

    logic [7:0] co;
    part_t      pt;
    logic       bad_end;

    // Verdict for a terminator in the current state.
    assign bad_end = state_cur.failed || (state_cur.phase == PH_SCHEME) ||
                     (state_cur.phase == PH_SLASH1) || (state_cur.phase == PH_SLASH2) ||
                     ((state_cur.phase == PH_HOST) && !state_cur.host_seen);

    // Phase machine step and tagging of the byte.
    always_comb begin
        state_next = state_cur;
        co         = ch;
        pt         = PART_SEP;
        if (!state_cur.failed) begin
            case (state_cur.phase)
                PH_SCHEME: begin
                    if (ch == CH_COLON) begin
                        if (state_cur.scheme_count > max_scheme_len) begin
                            state_next.failed = 1'b1;
                        end else begin
                            state_next.phase = PH_SLASH1;
                        end
                    end else begin
                        if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
                            co = ch + CASE_OFFSET;
                        end
                        pt = PART_SCHEME;
                        if (state_cur.scheme_count != SCHEME_COUNT_MAX) begin
                            state_next.scheme_count = state_cur.scheme_count + 4'd1;
                        end
                    end
                end
                PH_SLASH1: begin
                    if (ch == CH_SLASH) state_next.phase = PH_SLASH2;
                    else                state_next.failed = 1'b1;
                end
                PH_SLASH2: begin
                    if (ch == CH_SLASH) state_next.phase = PH_HOST;
                    else                state_next.failed = 1'b1;
                end
                PH_HOST: begin
                    if (ch == CH_COLON || ch == CH_SLASH) begin
                        if (!state_cur.host_seen) begin
                            state_next.failed = 1'b1;
                        end else begin
                            state_next.phase = (ch == CH_COLON) ? PH_PORT : PH_PATH;
                        end
                    end else begin
                        pt = PART_HOST;
                        state_next.host_seen = 1'b1;
                    end
                end
                PH_PORT: begin
                    if (ch == CH_SLASH) state_next.phase = PH_PATH;
                    else                pt = PART_PORT;
                end
                PH_PATH: begin
                    if (ch == CH_QUESTION)  state_next.phase = PH_QUERY;
                    else if (ch == CH_HASH) state_next.phase = PH_FRAG;
                    else                    pt = PART_PATH;
                end
                PH_QUERY: begin
                    if (ch == CH_HASH) state_next.phase = PH_FRAG;
                    else               pt = PART_QUERY;
                end
                PH_FRAG: begin
                    pt = PART_FRAG;
                end
                default: begin
                    pt = PART_SEP;
                end
            endcase
        end

        // A rejected URL reports raw bytes as separators.
        if (state_next.failed) begin
            co = ch;
            pt = PART_SEP;
        end

        result.char_out = co;
        result.part     = pt;
        result.error    = state_next.failed;
        result.url_end  = 1'b0;

        // The terminator gives the verdict and restarts the URL.
        if (ch == CH_NUL) begin
            state_next      = URL_STATE_RESET;
            result.char_out = CH_NUL;
            result.part     = PART_END;
            result.error    = bad_end;
            result.url_end  = 1'b1;
        end
    end

endmodule

### rtl/url_component_splitter_core.sv
// Top level of the URL component splitter: input register, classifier and result register.
// Depends on ucs_pkg and ucs_classify.
//
// Splits a URL streamed one byte per item into scheme, host, port, path, query and
// fragment, one result item per input item; a byte of zero ends the URL, sets m_tlast and
// carries the verdict in the error bit. The block takes one item per clock cycle while
// results are taken. The byte sits in the input register while the classifier works on it,
// and the result register captures the outcome. Both registers advance whenever the result
// register is empty or being taken; while a result waits on m_tready the input register
// still takes one more item, and s_tready then stays low until the result is taken.
// max_scheme_len is written through the cfg port and should only be
// changed between URLs while the block is empty.
module url_component_splitter_core (
    input  logic       aclk,
    input  logic       aresetn,
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [3:0] m_tuser,   // [2:0] part, [3] error
    output logic       m_tlast,   // url_end
    // Configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data   // max_scheme_len
);
    import ucs_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    url_state_t state_reg;
    url_state_t state_next;
    result_t    result_next;
    logic [3:0] max_len_reg;
    logic       out_free;
    logic       advance;

    // Result register can take a new item when empty or being drained.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg <= s_tdata;
        end
    end

    ucs_classify u_classify (
        .ch             (in_ch_reg),
        .max_scheme_len (max_len_reg),
        .state_cur      (state_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // Parsing state and result register move together with each item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= URL_STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= SCHEME_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.char_out;
    assign m_tuser  = {out_reg.error, out_reg.part};
    assign m_tlast  = out_reg.url_end;

endmodule

### rtl/ucs_checker.sv
// Port-level checker for the URL component splitter, bound to the top level.
// Depends on ucs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ucs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    import ucs_pkg::*;

    logic [2:0]  part_tag;
    logic        err_flag;
    logic        end_ok;
    logic [12:0] out_word;

    // Named views of the result fields.
    assign part_tag = m_tuser[2:0];
    assign err_flag = m_tuser[3];
    assign end_ok   = (m_tdata == CH_NUL) && (part_tag == PART_END);
    assign out_word = {m_tlast, m_tuser, m_tdata};

    // A terminator item carries a zero byte and the terminator tag.
    `ASSERT_IMPLY(a_end_tagged, aclk, aresetn, m_tvalid && m_tlast, end_ok)

    // Only the terminator carries the terminator tag.
    `ASSERT_IMPLY(a_tag_only_end, aclk, aresetn, m_tvalid && !m_tlast, part_tag != PART_END)

    // Bytes of a rejected URL are reported as separators.
    `ASSERT_IMPLY(a_err_sep, aclk, aresetn, m_tvalid && err_flag && !m_tlast, part_tag == PART_SEP)

    // A stalled result holds its contents.
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind url_component_splitter_core ucs_checker u_ucs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
